// ===== rtl/core/ucd_pkg.sv =====
// Shared types, decode functions and controller encodings for the UTF-8 code point decoder.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package ucd_pkg;

  localparam int ByteW  = 8;
  localparam int CpW    = 21;
  localparam int CntW   = 3;   // holds 0..4 buffered bytes
  localparam int BufN   = 4;
  localparam int IdxW   = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FLUSH
  } ucd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // accept a byte that does not end the text
    logic take_final;  // accept the final byte into the buffer
    logic flush_step;  // emit one end-of-text result and drop its bytes
  } ucd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic byte_emits;  // the incoming byte completes a code point
    logic flush_last;  // the current flush result empties the buffer
  } ucd_sts_t;

  typedef struct packed {
    cp_t  cp;
    logic err;
    logic complete;  // the sequence fits in the bytes available
    cnt_t used;      // bytes consumed by this result
  } ucd_dec_t;

  // Sequence length started by a lead byte; zero when the byte cannot lead.
  function automatic cnt_t seq_len(input byte_t c);
    cnt_t len;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Decodes the sequence that starts at w0, given how many bytes are present.
  function automatic ucd_dec_t decode(input byte_t w0, input byte_t w1, input byte_t w2,
                                      input byte_t w3, input cnt_t avail);
    ucd_dec_t d;
    cnt_t     len;
    len        = seq_len(w0);
    d.cp       = '0;
    d.err      = 1'b0;
    d.complete = 1'b1;
    d.used     = len;
    if (len == 3'd0) begin
      d.err  = 1'b1;
      d.used = 3'd1;
    end else if (len > avail) begin
      d.err      = 1'b1;
      d.complete = 1'b0;
      d.used     = 3'd1;
    end else begin
      case (len)
        3'd1:    d.cp = CpW'(w0);
        3'd2:    d.cp = CpW'({w0[4:0], w1[5:0]});
        3'd3:    d.cp = CpW'({w0[3:0], w1[5:0], w2[5:0]});
        3'd4:    d.cp = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
        default: d.cp = '0;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/ucd_ctrl.sv =====
// Controller state machine of the UTF-8 code point decoder: handshakes and flush sequencing.
// Depends on ucd_pkg; drives ucd_dp through command and status structs.
module ucd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final_byte,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ucd_pkg::ucd_sts_t sts,
  output ucd_pkg::ucd_cmd_t cmd
);

  ucd_pkg::ucd_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ucd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ucd_pkg::ST_IDLE: begin
        if (in_valid && out_free && in_final_byte) begin
          state_nxt = ucd_pkg::ST_FLUSH;
        end
      end
      ucd_pkg::ST_FLUSH: begin
        if (out_free && sts.flush_last) begin
          state_nxt = ucd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ucd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ucd_pkg::ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (in_final_byte) begin
            cmd.take_final = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            out_valid_nxt = sts.byte_emits;
          end
        end
      end
      ucd_pkg::ST_FLUSH: begin
        if (out_free) begin
          cmd.flush_step = 1'b1;
          out_valid_nxt  = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/ucd_dp.sv =====
// Datapath of the UTF-8 code point decoder: byte buffer, two sequence decoders (streaming and flush), result register.
// Depends on ucd_pkg; controlled by ucd_ctrl.
module ucd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ucd_pkg::byte_t    in_text_byte,
  input  ucd_pkg::ucd_cmd_t cmd,
  output ucd_pkg::ucd_sts_t sts,
  output ucd_pkg::cp_t      out_code_point,
  output logic              out_decode_error,
  output logic              out_run_last,
  output logic              out_text_end
);

  ucd_pkg::byte_t   buf_r [ucd_pkg::BufN];
  ucd_pkg::byte_t   buf_nxt [ucd_pkg::BufN];
  ucd_pkg::byte_t   win [ucd_pkg::BufN];
  ucd_pkg::cnt_t    cnt_r, cnt_nxt;
  ucd_pkg::cp_t     cp_r, cp_nxt;
  logic             err_r, err_nxt;
  logic             run_last_r, run_last_nxt;
  logic             text_end_r, text_end_nxt;
  ucd_pkg::ucd_dec_t dec_byte, dec_flush;

  // Window for a streaming byte: the held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < ucd_pkg::BufN; i++) begin
      win[i] = (ucd_pkg::CntW'(i) < cnt_r) ? buf_r[i] : in_text_byte;
    end
  end

  assign dec_byte  = ucd_pkg::decode(win[0], win[1], win[2], win[3], cnt_r + 3'd1);
  assign dec_flush = ucd_pkg::decode(buf_r[0], buf_r[1], buf_r[2], buf_r[3], cnt_r);

  assign sts.byte_emits = dec_byte.complete;
  assign sts.flush_last = (dec_flush.used == cnt_r);

  always_comb begin
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    cp_nxt       = cp_r;
    err_nxt      = err_r;
    run_last_nxt = run_last_r;
    text_end_nxt = text_end_r;
    if (cmd.take_byte) begin
      if (dec_byte.complete) begin
        cnt_nxt      = '0;
        cp_nxt       = dec_byte.cp;
        err_nxt      = dec_byte.err;
        run_last_nxt = 1'b1;
        text_end_nxt = 1'b0;
      end else begin
        buf_nxt[cnt_r[ucd_pkg::IdxW-1:0]] = in_text_byte;
        cnt_nxt = cnt_r + 3'd1;
      end
    end else if (cmd.take_final) begin
      buf_nxt[cnt_r[ucd_pkg::IdxW-1:0]] = in_text_byte;
      cnt_nxt = cnt_r + 3'd1;
    end else if (cmd.flush_step) begin
      // Drop the consumed bytes so the next lead always sits at the front.
      for (int i = 0; i < ucd_pkg::BufN; i++) begin
        case (dec_flush.used)
          3'd1:    if (i + 1 < ucd_pkg::BufN) buf_nxt[i] = buf_r[(i + 1) % ucd_pkg::BufN];
          3'd2:    if (i + 2 < ucd_pkg::BufN) buf_nxt[i] = buf_r[(i + 2) % ucd_pkg::BufN];
          3'd3:    if (i + 3 < ucd_pkg::BufN) buf_nxt[i] = buf_r[(i + 3) % ucd_pkg::BufN];
          default: buf_nxt[i] = buf_r[i];
        endcase
      end
      cnt_nxt      = cnt_r - dec_flush.used;
      cp_nxt       = dec_flush.cp;
      err_nxt      = dec_flush.err;
      run_last_nxt = sts.flush_last;
      text_end_nxt = sts.flush_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    cp_r       <= cp_nxt;
    err_r      <= err_nxt;
    run_last_r <= run_last_nxt;
    text_end_r <= text_end_nxt;
  end

  assign out_code_point   = cp_r;
  assign out_decode_error = err_r;
  assign out_run_last     = run_last_r;
  assign out_text_end     = text_end_r;

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_step |-> cnt_r != 3'd0)
    else $error("flush step with an empty buffer");

  a_stream_holds_partial: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte && !dec_byte.complete |=> cnt_r != 3'd0 && cnt_r != 3'd4)
    else $error("held sequence count out of range");

endmodule

// ===== rtl/core/utf8_codepoint_decoder.sv =====
// Top level of the UTF-8 code point decoder: joins the controller and the datapath.
// Depends on ucd_pkg, ucd_ctrl and ucd_dp.

// This block turns a UTF-8 text, one byte per word on the input channel, into code points on
// the output channel. A byte below 0x80 is a code point by itself; a lead byte 0xC0-0xDF,
// 0xE0-0xEF or 0xF0-0xF7 opens a sequence of two, three or four bytes whose trailing bytes
// contribute their low six bits without being checked as continuation bytes. A byte that
// cannot lead (0x80-0xBF, 0xF8-0xFF) gives code point 0 with decode_error set. Bytes that
// open or extend a sequence are held and produce no word; the byte that completes it
// produces exactly one. Every result word carries run_last on the last word caused by its
// input byte. When in_final_byte is set, the held bytes plus the final byte are decoded as a
// complete text: a lead whose sequence does not fit gives 0 with decode_error, and the
// bytes after it are decoded again as new leads, so the final byte causes one to four
// words, the last of which carries text_end. Throughput is one byte per cycle for every
// byte that does not end the text, while the output is not stalled. After the final byte
// is accepted, the flush emits its result words one after another while a second sequence
// decoder walks the four-byte buffer; in_stall stays high during that flush. A result waits
// in an output register, so a new byte is accepted in the same cycle the pending word is taken.
// Both channels use valid/stall: a word moves on a clock edge with valid high and stall low.
module utf8_codepoint_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ucd_pkg::byte_t       in_text_byte,
  input  logic                 in_final_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ucd_pkg::cp_t         out_code_point,
  output logic                 out_decode_error,
  output logic                 out_run_last,
  output logic                 out_text_end
);

  ucd_pkg::ucd_cmd_t cmd;
  ucd_pkg::ucd_sts_t sts;

  // The controller owns the handshakes and decides when the datapath loads its result
  // register; the datapath reports whether a byte completes a code point and whether a
  // flush result drains the buffer.
  ucd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_byte (in_final_byte),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // The datapath keeps up to four bytes: the sequence in progress and, at the end of a
  // text, the final byte. Separate decoders serve the streaming path and the flush walk.
  ucd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_text_byte     (in_text_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_code_point   (out_code_point),
    .out_decode_error (out_decode_error),
    .out_run_last     (out_run_last),
    .out_text_end     (out_text_end)
  );

  // The end of a text is always the last word of its byte.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("text end without run last");

  // A failed decode always reports code point zero.
  a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_error |-> out_code_point == '0)
    else $error("decode error with nonzero code point");

  // Accepting the final byte starts a flush, during which no byte is taken.
  a_final_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_byte |=> in_stall)
    else $error("input accepted right after the final byte");

endmodule

// ===== bench/utf8_codepoint_decoder_test.sv =====
// Self-checking testbench for utf8_codepoint_decoder: drives UTF-8 bytes, predicts code points.
// Depends on ucd_pkg for the port types and on the utf8_codepoint_decoder RTL.
`timescale 1ns / 1ps

module utf8_codepoint_decoder_test;

  localparam int CycleLimit = 200000;
  localparam int PhaseWords = 33;
  localparam int DrainWait  = 8;

  // One decoded result as the block is expected to present it.
  typedef struct {
    ucd_pkg::cp_t cp;
    logic         err;
    logic         run_last;
    logic         text_end;
  } cp_word_t;

  // Tracks the decoder's held sequence and keeps the code points that are still owed.
  class codepoint_scoreboard;
    cp_word_t       owed_q[$];
    ucd_pkg::byte_t held[3];
    int unsigned    held_n;
    int unsigned    mismatches;
    int unsigned    words_in;
    int unsigned    words_out;
    int unsigned    flagged;
    int unsigned    texts;
    int unsigned    widest;

    function new();
      held_n     = 0;
      mismatches = 0;
      words_in   = 0;
      words_out  = 0;
      flagged    = 0;
      texts      = 0;
      widest     = 0;
    endfunction

    function int lead_length(ucd_pkg::byte_t c);
      if (c[7] == 1'b0) return 1;
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 0;
    endfunction

    function ucd_pkg::cp_t join_bytes(ucd_pkg::byte_t seq[4], int start, int len);
      logic [31:0] acc;
      case (len)
        2:       acc = {27'd0, seq[start][4:0]};
        3:       acc = {28'd0, seq[start][3:0]};
        default: acc = {29'd0, seq[start][2:0]};
      endcase
      for (int k = 1; k < len; k++) begin
        acc = (acc << 6) | {26'd0, seq[start+k][5:0]};
      end
      return acc[20:0];
    endfunction

    // Called once per accepted input word.
    function void note_input(ucd_pkg::byte_t b, logic fin);
      cp_word_t       batch[4];
      ucd_pkg::byte_t seq[4];
      int             n;
      int             len;
      int             total;
      int             pos;
      n = 0;
      words_in++;
      if (!fin) begin
        if (held_n == 0) begin
          len = lead_length(b);
          if (len == 1) begin
            batch[n++] = '{ucd_pkg::cp_t'(b), 1'b0, 1'b0, 1'b0};
          end else if (len == 0) begin
            batch[n++] = '{'0, 1'b1, 1'b0, 1'b0};
          end else begin
            held[0] = b;
            held_n  = 1;
          end
        end else begin
          len = lead_length(held[0]);
          if (held_n + 1 >= len) begin
            for (int k = 0; k < held_n; k++) seq[k] = held[k];
            seq[held_n] = b;
            batch[n++]  = '{join_bytes(seq, 0, held_n + 1), 1'b0, 1'b0, 1'b0};
            held_n      = 0;
          end else begin
            held[held_n] = b;
            held_n++;
          end
        end
      end else begin
        total = 0;
        for (int k = 0; k < held_n; k++) seq[total++] = held[k];
        seq[total++] = b;
        held_n = 0;
        pos    = 0;
        while (pos < total) begin
          len = lead_length(seq[pos]);
          if (len == 1) begin
            batch[n++] = '{ucd_pkg::cp_t'(seq[pos]), 1'b0, 1'b0, 1'b0};
            pos++;
          end else if (len == 0 || pos + len > total) begin
            batch[n++] = '{'0, 1'b1, 1'b0, 1'b0};
            pos++;
          end else begin
            batch[n++] = '{join_bytes(seq, pos, len), 1'b0, 1'b0, 1'b0};
            pos += len;
          end
        end
        batch[n-1].text_end = 1'b1;
        texts++;
      end
      if (n > 0) batch[n-1].run_last = 1'b1;
      if (n > widest) widest = n;
      for (int k = 0; k < n; k++) owed_q.push_back(batch[k]);
    endfunction

    // Called once per accepted result word.
    function void check_result(ucd_pkg::cp_t cp, logic err, logic run_last, logic text_end);
      cp_word_t want;
      words_out++;
      if (err) flagged++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result cp=%06h err=%0b run_last=%0b text_end=%0b",
                 $time, cp, err, run_last, text_end);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (cp !== want.cp) begin
        $display("%0t: code_point expected %06h actual %06h", $time, want.cp, cp);
        mismatches++;
      end
      if (err !== want.err) begin
        $display("%0t: decode_error expected %0b actual %0b", $time, want.err, err);
        mismatches++;
      end
      if (run_last !== want.run_last) begin
        $display("%0t: run_last expected %0b actual %0b", $time, want.run_last, run_last);
        mismatches++;
      end
      if (text_end !== want.text_end) begin
        $display("%0t: text_end expected %0b actual %0b", $time, want.text_end, text_end);
        mismatches++;
      end
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic           clk           = 1'b0;
  logic           rst_n         = 1'b0;
  logic           in_valid      = 1'b0;
  logic           in_stall;
  ucd_pkg::byte_t in_text_byte  = '0;
  logic           in_final_byte = 1'b0;
  logic           out_valid;
  logic           out_stall     = 1'b0;
  ucd_pkg::cp_t   out_code_point;
  logic           out_decode_error;
  logic           out_run_last;
  logic           out_text_end;

  codepoint_scoreboard sb = new();

  // Idle and stall percentages for the current phase of the run.
  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycles        = 0;
  int unsigned phase_sent    = 0;

  utf8_codepoint_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_decode_error (out_decode_error),
    .out_run_last     (out_run_last),
    .out_text_end     (out_text_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Global watchdog. A correct run finishes far below this limit even with the heaviest
  // idling and the longest flushes, so reaching it means the block hung or lost a word.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results still owed", $time, sb.owed());
      $display("[utf8_codepoint_decoder] ERROR");
      $finish;
    end
  end

  // Result side. The sampled values are the ones that were present before this edge, so a
  // word counts as taken exactly when valid was high and our stall was low. The stall for the
  // next cycle is then chosen at random, with a fresh roll on every cycle so that stalls land
  // on single results as well as in the middle of an end-of-text flush.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_code_point, out_decode_error, out_run_last, out_text_end);
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Presents one input word and returns on the edge at which the block takes it. The word
  // stays on the port, unchanged, for as long as the block stalls. Between calls the valid
  // line gets exactly one assignment per edge: either it drops for an idle cycle or it stays
  // high with the next word, so back-to-back words never see a lowered valid.
  task automatic send_word(input ucd_pkg::byte_t b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_input(b, fin);
    phase_sent++;
  endtask

  // Sends one character of a random text. Most characters are well-formed sequences with
  // random payload bits; some carry a trailing byte that is not a continuation byte, some are
  // bytes that cannot lead, and some are raw noise. Now and then the text ends on the
  // character, sometimes before its sequence is complete, which exercises the flush path.
  task automatic send_random_char();
    ucd_pkg::byte_t seq[4];
    int             kind;
    int             len;
    int             cut;
    logic           ends;
    kind = $urandom_range(99);
    len  = 1;
    if (kind < 30) begin
      seq[0] = ucd_pkg::byte_t'($urandom_range(0, 127));
    end else if (kind < 48) begin
      len    = 2;
      seq[0] = 8'hC0 | ucd_pkg::byte_t'($urandom_range(0, 31));
    end else if (kind < 64) begin
      len    = 3;
      seq[0] = 8'hE0 | ucd_pkg::byte_t'($urandom_range(0, 15));
    end else if (kind < 78) begin
      len    = 4;
      seq[0] = 8'hF0 | ucd_pkg::byte_t'($urandom_range(0, 7));
    end else if (kind < 88) begin
      seq[0] = $urandom_range(0, 1) ? (8'h80 | ucd_pkg::byte_t'($urandom_range(0, 63)))
                                    : (8'hF8 | ucd_pkg::byte_t'($urandom_range(0, 7)));
    end else begin
      seq[0] = ucd_pkg::byte_t'($urandom_range(0, 255));
    end
    for (int k = 1; k < 4; k++) begin
      seq[k] = ($urandom_range(99) < 90) ? {2'b10, 6'($urandom_range(0, 63))}
                                         : ucd_pkg::byte_t'($urandom_range(0, 255));
    end
    ends = ($urandom_range(99) < 18);
    cut  = ends ? $urandom_range(1, len) : len;
    for (int k = 0; k < cut; k++) begin
      send_word(seq[k], ends && (k == cut - 1));
    end
  endtask

  // Main sequence: reset, a directed pass over the corner cases, four random phases with
  // different idling and output stalls, then a drain and the verdict.
  initial begin
    int unsigned send_pcts[4];
    int unsigned stall_pcts[4];
    send_pcts  = '{0, 53, 0, 14};
    stall_pcts = '{0, 0, 53, 14};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Plain ASCII at both ends of its range, then bytes that cannot lead.
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hF8, 1'b0);
    // Complete two, three and four byte sequences, the last one at the largest value.
    send_word(8'hC2, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    send_word(8'hF7, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    // A trailing byte that is not a continuation byte is merged anyway.
    send_word(8'hC3, 1'b0);
    send_word(8'h41, 1'b0);
    // Text ends on a four byte lead and three letters, which are merged into one code point.
    send_word(8'hF0, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b0);
    send_word(8'h43, 1'b1);
    // Truncated three byte sequence at the end, then single-byte texts.
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b1);
    send_word(8'hC3, 1'b1);
    send_word(8'h41, 1'b1);
    send_word(8'hBF, 1'b1);
    // A sequence that the final byte completes.
    send_word(8'hDF, 1'b0);
    send_word(8'hBF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      out_stall_pct = stall_pcts[ph];
      phase_sent    = 0;
      while (phase_sent < PhaseWords) begin
        send_random_char();
      end
    end
    // Close whatever text is still open so its held bytes are flushed.
    send_word(8'h41, 1'b1);
    in_valid <= 1'b0;

    while (sb.owed() != 0) begin
      @(posedge clk);
    end
    repeat (DrainWait) @(posedge clk);

    $display("Sent %0d bytes over %0d texts; checked %0d code points, %0d with decode_error.",
             sb.words_in, sb.texts, sb.words_out, sb.flagged);
    $display("Largest burst from one byte: %0d results; mismatches: %0d.",
             sb.widest, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("[utf8_codepoint_decoder] OK");
    end else begin
      $display("[utf8_codepoint_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ucd_pkg.sv
rtl/core/ucd_ctrl.sv
rtl/core/ucd_dp.sv
rtl/core/utf8_codepoint_decoder.sv
bench/utf8_codepoint_decoder_test.sv
